FILE: sv/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types, widths and codes of the wall column ray caster.
// ----------------------------------------------------------------------------
package dwc_pkg;

	localparam int POS_W    = 16;
	localparam int FRAC_W   = 11;
	localparam int RAY_W    = 18;
	localparam int DELTA_W  = 32;
	localparam int SD_W     = 40;
	localparam int COORD_W  = 8;
	localparam int TILE_W   = 3;
	localparam int COL_W    = 9;
	localparam int TXY_W    = 5;
	localparam int ROW_W    = 8;
	localparam int MSIZE_W  = 6;
	localparam int DIVQ_W   = 32;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [DELTA_W-1:0] DELTA_SAT = '1;

	localparam logic CMD_CAST  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [2:0] {
		REG_POS_X   = 3'd0,
		REG_POS_Y   = 3'd1,
		REG_DIR_X   = 3'd2,
		REG_DIR_Y   = 3'd3,
		REG_PLANE_X = 3'd4,
		REG_PLANE_Y = 3'd5,
		REG_MAP_W   = 3'd6,
		REG_MAP_H   = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CAM_GO, ST_CAM_WT, ST_RAY_X, ST_RAY_Y, ST_RAY_ADD,
		ST_DX_GO, ST_DX_WT, ST_DY_GO, ST_DY_WT, ST_SIDE_X, ST_SIDE_Y,
		ST_STEP, ST_CHECK, ST_LH_GO, ST_LH_WT, ST_WALL, ST_FINISH
	} cast_state_t;

	typedef struct packed {
		logic              start;
		logic [DIVQ_W-1:0] dividend;
		logic [SD_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVQ_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: sv/dwc_req_if.sv
// ----------------------------------------------------------------------------
// dwc_req_if
// Command channel: cast a column or write one map tile.
// ----------------------------------------------------------------------------
interface dwc_req_if import dwc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [COL_W-1:0]  column;
	logic [TXY_W-1:0]  tile_x;
	logic [TXY_W-1:0]  tile_y;
	logic [TILE_W-1:0] tile_value;

	modport source(output valid, command, column, tile_x, tile_y, tile_value, input ready);
	modport sink(input valid, command, column, tile_x, tile_y, tile_value, output ready);
endinterface

FILE: sv/dwc_res_if.sv
// ----------------------------------------------------------------------------
// dwc_res_if
// Result channel: one wall slice per cast column.
// ----------------------------------------------------------------------------
interface dwc_res_if import dwc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  column_out;
	logic [ROW_W-1:0]  draw_start;
	logic [ROW_W-1:0]  draw_end;
	logic [TILE_W-1:0] hit_tile;
	logic              hit_side;
	logic              stripe;

	modport source(output valid, column_out, draw_start, draw_end, hit_tile, hit_side,
		stripe, input ready);
	modport sink(input valid, column_out, draw_start, draw_end, hit_tile, hit_side,
		stripe, output ready);
endinterface

FILE: sv/dda_wall_column_raycaster.sv
// ----------------------------------------------------------------------------
// dda_wall_column_raycaster
// Grid ray caster: tile map in a synchronous memory, one wall slice per cast.
// ----------------------------------------------------------------------------
// A tile write gives no result. A cast forms the camera coordinate by a
// constant reciprocal multiply and the ray (x and y products, then the sum).
// It then runs up to three divisions on one shared serial divider (two
// reciprocals, line height). It walks the grid cell by cell (step, then the
// registered map read), at most 2*MAP_DIM+4 cells. A zero ray component or
// zero distance skips its division. A stalled output adds its stall before
// the next item is taken. One item is worked at a time; a finished slice
// waits in the output register while the next item is taken.
// The tile memory is not cleared at reset: write every cell inside the map
// size in use before casting. Cells outside map_width by map_height read as
// wall kind 1.
// ----------------------------------------------------------------------------
module dda_wall_column_raycaster import dwc_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240,
	parameter int MAP_DIM       = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	dwc_req_if.sink            request,
	dwc_res_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	localparam int ADDR_W    = $clog2(MAP_DIM * MAP_DIM);
	localparam int MAX_STEPS = 2 * MAP_DIM + 4;
	localparam int NCNT_W    = $clog2(MAX_STEPS);
	localparam int LINE_SAT  = 4 * SCREEN_HEIGHT;
	localparam int LH_W      = $clog2(LINE_SAT + 1);
	localparam int CAMN_W    = 13;
	// Camera divide by the screen width as a multiply by a rounded-up reciprocal
	localparam int CAM_SH    = CAMN_W + $clog2(SCREEN_WIDTH);
	localparam int CAM_M_W   = CAMN_W + 16;
	localparam int CAMP_W    = CAMN_W + CAM_M_W;
	localparam longint unsigned CAM_M =
		((64'd1 << (CAM_SH + 14)) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);

	// Configuration registers
	logic [POS_W-1:0]   pos_x_q, pos_y_q;
	logic [POS_W-1:0]   dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [MSIZE_W-1:0] map_w_q, map_h_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= 16'd3072;
			pos_y_q   <= 16'd3072;
			dir_x_q   <= 16'd16384;
			dir_y_q   <= 16'd0;
			plane_x_q <= 16'd0;
			plane_y_q <= 16'd10813;
			map_w_q   <= 6'd10;
			map_h_q   <= 6'd10;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_POS_X:   pos_x_q   <= pwdata[POS_W-1:0];
				REG_POS_Y:   pos_y_q   <= pwdata[POS_W-1:0];
				REG_DIR_X:   dir_x_q   <= pwdata[POS_W-1:0];
				REG_DIR_Y:   dir_y_q   <= pwdata[POS_W-1:0];
				REG_PLANE_X: plane_x_q <= pwdata[POS_W-1:0];
				REG_PLANE_Y: plane_y_q <= pwdata[POS_W-1:0];
				REG_MAP_W:   map_w_q   <= pwdata[MSIZE_W-1:0];
				REG_MAP_H:   map_h_q   <= pwdata[MSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[4:2]))
			REG_POS_X:   prdata = PDATA_W'(pos_x_q);
			REG_POS_Y:   prdata = PDATA_W'(pos_y_q);
			REG_DIR_X:   prdata = PDATA_W'(dir_x_q);
			REG_DIR_Y:   prdata = PDATA_W'(dir_y_q);
			REG_PLANE_X: prdata = PDATA_W'(plane_x_q);
			REG_PLANE_Y: prdata = PDATA_W'(plane_y_q);
			REG_MAP_W:   prdata = PDATA_W'(map_w_q);
			REG_MAP_H:   prdata = PDATA_W'(map_h_q);
			default:     prdata = '0;
		endcase
	end

	// Cast state
	cast_state_t state_q, state_d;

	logic               req_acc;
	logic [COL_W-1:0]   col_q;
	logic [CAMP_W-1:0]  cam_prod_q;
	logic [16:0]        cam_q;
	logic [31:0]        prodx_q, prody_q;
	logic [RAY_W-1:0]   rx_q, ry_q;
	logic [RAY_W-1:0]   ax, ay;
	logic [DELTA_W-1:0] ddx_q, ddy_q;
	logic [SD_W-1:0]    sdx_q, sdy_q;
	logic [COORD_W-1:0] mx_q, my_q;
	logic               side_q;
	logic [NCNT_W-1:0]  n_q;
	logic               outside_q;
	logic [TILE_W-1:0]  rdata_q;
	logic [TILE_W-1:0]  hit_q;
	logic [SD_W-1:0]    perp_q;
	logic [LH_W-1:0]    lh_q;
	logic [27:0]        wallp_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	dwc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign request.ready = (state_q == ST_IDLE);
	assign req_acc       = request.valid && request.ready;

	assign ax = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : rx_q;
	assign ay = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : ry_q;

	// Camera numerator 2*column - width; scale its magnitude, fix the sign after
	logic signed [CAMN_W-1:0] cam_num;
	logic [CAMN_W-1:0]        cam_mag;
	assign cam_num = $signed({3'b000, col_q, 1'b0}) - CAMN_W'(SCREEN_WIDTH);
	assign cam_mag = cam_num[CAMN_W-1] ? CAMN_W'(-cam_num) : CAMN_W'(cam_num);

	// DDA step: advance along the nearer side
	logic               step_x;
	logic [COORD_W-1:0] nmx, nmy;
	logic [31:0]        w_lim, h_lim;
	logic               n_outside;
	logic [ADDR_W-1:0]  rd_addr, wr_addr;
	logic               wr_en;

	assign step_x = sdx_q < sdy_q;
	assign nmx = step_x ? (rx_q[RAY_W-1] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign nmy = step_x ? my_q : (ry_q[RAY_W-1] ? my_q - 1'b1 : my_q + 1'b1);
	assign w_lim = (32'(map_w_q) > 32'(MAP_DIM)) ? 32'(MAP_DIM) : 32'(map_w_q);
	assign h_lim = (32'(map_h_q) > 32'(MAP_DIM)) ? 32'(MAP_DIM) : 32'(map_h_q);
	assign n_outside = nmx[COORD_W-1] || nmy[COORD_W-1]
		|| (32'(nmx) >= w_lim) || (32'(nmy) >= h_lim);
	assign rd_addr = ADDR_W'(32'(nmy) * MAP_DIM + 32'(nmx));
	assign wr_addr = ADDR_W'(32'(request.tile_y) * MAP_DIM + 32'(request.tile_x));
	assign wr_en = req_acc && (request.command == CMD_WRITE)
		&& (32'(request.tile_x) < 32'(MAP_DIM)) && (32'(request.tile_y) < 32'(MAP_DIM));

	// Tile memory: one write and one registered read per cycle
	logic [TILE_W-1:0] tile_mem [MAP_DIM*MAP_DIM];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tile_mem[wr_addr] <= request.tile_value;
		end
		rdata_q <= tile_mem[rd_addr];
	end

	// Hit evaluation at the cell just read
	logic [TILE_W-1:0] cur_tile;
	logic              walk_end;
	assign cur_tile = outside_q ? TILE_W'(1) : rdata_q;
	assign walk_end = (cur_tile != '0) || (n_q == NCNT_W'(MAX_STEPS - 1));

	// Output slot
	logic out_free;
	assign out_free = !result.valid || result.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (req_acc && request.command == CMD_CAST) state_d = ST_CAM_GO;
			ST_CAM_GO:  state_d = ST_CAM_WT;
			ST_CAM_WT:  state_d = ST_RAY_X;
			ST_RAY_X:   state_d = ST_RAY_Y;
			ST_RAY_Y:   state_d = ST_RAY_ADD;
			ST_RAY_ADD: state_d = ST_DX_GO;
			ST_DX_GO:   state_d = (ax == '0) ? ST_DY_GO : ST_DX_WT;
			ST_DX_WT:   if (div_rsp.done) state_d = ST_DY_GO;
			ST_DY_GO:   state_d = (ay == '0) ? ST_SIDE_X : ST_DY_WT;
			ST_DY_WT:   if (div_rsp.done) state_d = ST_SIDE_X;
			ST_SIDE_X:  state_d = ST_SIDE_Y;
			ST_SIDE_Y:  state_d = ST_STEP;
			ST_STEP:    state_d = ST_CHECK;
			ST_CHECK:   state_d = walk_end ? ST_LH_GO : ST_STEP;
			ST_LH_GO:   state_d = (perp_q == '0) ? ST_WALL : ST_LH_WT;
			ST_LH_WT:   if (div_rsp.done) state_d = ST_WALL;
			ST_WALL:    state_d = ST_FINISH;
			ST_FINISH:  if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		div_req = '0;
		case (state_q)
			ST_DX_GO: begin
				div_req.start    = (ax != '0);
				div_req.dividend = DIVQ_W'(32'h4000_0000);
				div_req.divisor  = SD_W'(ax);
			end
			ST_DY_GO: begin
				div_req.start    = (ay != '0);
				div_req.dividend = DIVQ_W'(32'h4000_0000);
				div_req.divisor  = SD_W'(ay);
			end
			ST_LH_GO: begin
				div_req.start    = (perp_q != '0);
				div_req.dividend = DIVQ_W'(SCREEN_HEIGHT) << 16;
				div_req.divisor  = perp_q;
			end
			default: div_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Side distance start terms: fraction to the next grid line
	logic [FRAC_W:0] fx, fy;
	assign fx = rx_q[RAY_W-1] ? {1'b0, pos_x_q[FRAC_W-1:0]}
		: (12'd2048 - {1'b0, pos_x_q[FRAC_W-1:0]});
	assign fy = ry_q[RAY_W-1] ? {1'b0, pos_y_q[FRAC_W-1:0]}
		: (12'd2048 - {1'b0, pos_y_q[FRAC_W-1:0]});

	logic [43:0] sidex_p, sidey_p;
	assign sidex_p = 44'(fx) * 44'(ddx_q);
	assign sidey_p = 44'(fy) * 44'(ddy_q);

	logic [31:0] q_clip;
	assign q_clip = (div_rsp.quotient > 32'(LINE_SAT)) ? 32'(LINE_SAT) : div_rsp.quotient;

	logic [RAY_W-1:0] wall_ray;
	assign wall_ray = side_q ? rx_q : ry_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q <= request.column;
			end
			ST_CAM_GO: cam_prod_q <= CAMP_W'(cam_mag) * CAMP_W'(CAM_M_W'(CAM_M));
			ST_CAM_WT: begin
				// truncate toward zero: divide the magnitude, then restore the sign
				cam_q <= cam_num[CAMN_W-1] ? 17'(-cam_prod_q[CAM_SH +: 17])
					: cam_prod_q[CAM_SH +: 17];
			end
			ST_RAY_X: prodx_q <= 32'($signed(plane_x_q) * $signed(cam_q));
			ST_RAY_Y: prody_q <= 32'($signed(plane_y_q) * $signed(cam_q));
			ST_RAY_ADD: begin
				// floor divide by 2^14 is the arithmetic drop of 14 bits
				rx_q <= RAY_W'($signed(dir_x_q)) + prodx_q[31:14];
				ry_q <= RAY_W'($signed(dir_y_q)) + prody_q[31:14];
			end
			ST_DX_GO: if (ax == '0) ddx_q <= DELTA_SAT;
			ST_DX_WT: if (div_rsp.done) ddx_q <= div_rsp.quotient;
			ST_DY_GO: if (ay == '0) ddy_q <= DELTA_SAT;
			ST_DY_WT: if (div_rsp.done) ddy_q <= div_rsp.quotient;
			ST_SIDE_X: begin
				sdx_q <= SD_W'(sidex_p[43:11]);
				mx_q  <= COORD_W'(pos_x_q[POS_W-1:FRAC_W]);
				n_q   <= '0;
			end
			ST_SIDE_Y: begin
				sdy_q <= SD_W'(sidey_p[43:11]);
				my_q  <= COORD_W'(pos_y_q[POS_W-1:FRAC_W]);
			end
			ST_STEP: begin
				if (step_x) begin
					sdx_q <= sdx_q + SD_W'(ddx_q);
				end else begin
					sdy_q <= sdy_q + SD_W'(ddy_q);
				end
				side_q    <= !step_x;
				mx_q      <= nmx;
				my_q      <= nmy;
				outside_q <= n_outside;
			end
			ST_CHECK: begin
				n_q   <= n_q + 1'b1;
				hit_q <= (cur_tile == '0) ? TILE_W'(1) : cur_tile;
				perp_q <= side_q ? (sdy_q - SD_W'(ddy_q)) : (sdx_q - SD_W'(ddx_q));
			end
			ST_LH_GO: if (perp_q == '0) lh_q <= LH_W'(LINE_SAT);
			ST_LH_WT: if (div_rsp.done) lh_q <= LH_W'(q_clip);
			ST_WALL: wallp_q <= perp_q[27:0] * 28'($signed(wall_ray));
			default: ;
		endcase
	end

	// Slice extent and stripe
	logic signed [LH_W+1:0] half, ds, de;
	logic [27:0]            wall;
	logic [POS_W-1:0]       wall_pos;

	assign half = $signed({2'b00, lh_q >> 1});
	assign ds = (LH_W+2)'(SCREEN_HEIGHT / 2) - half;
	assign de = half + (LH_W+2)'(SCREEN_HEIGHT / 2);
	assign wall_pos = side_q ? pos_x_q : pos_y_q;
	assign wall = {wall_pos[8:0], 19'd0} + wallp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result.column_out <= col_q;
			result.draw_start <= ds[LH_W+1] ? '0 : ROW_W'(ds);
			result.draw_end   <= (de >= (LH_W+2)'(SCREEN_HEIGHT))
				? ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(de);
			result.hit_tile   <= hit_q;
			result.hit_side   <= side_q;
			result.stripe     <= wall[27];
		end
	end
endmodule

FILE: sv/dwc_div.sv
// ----------------------------------------------------------------------------
// dwc_div
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module dwc_div import dwc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DIVQ_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SD_W-1:0]   rem_q;
	logic [DIVQ_W-1:0] quo_q;
	logic [SD_W-1:0]   dvs_q;
	logic [SD_W:0]     shifted;
	logic [SD_W+1:0]   diff;

	assign shifted = {rem_q, quo_q[DIVQ_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[SD_W+1]) begin
				rem_q <= diff[SD_W-1:0];
				quo_q <= {quo_q[DIVQ_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SD_W-1:0];
				quo_q <= {quo_q[DIVQ_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

FILE: tb/dda_wall_column_raycaster_tb.sv
// ----------------------------------------------------------------------------
// dda_wall_column_raycaster_tb
// Self-checking bench for the grid ray caster: walks a short table of hand-picked
// items, fills the tile map, then drives random casts and tile writes over a
// series of camera and map-size settings. Every slice is checked field by field
// against the slice given in its row or a fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module dda_wall_column_raycaster_tb;
	import dwc_pkg::*;

	localparam int SCR_W      = 320;
	localparam int SCR_H      = 240;
	localparam int MDIM       = 32;
	localparam int DRAIN_WAIT = 700;       // worst cast is well under this
	localparam int CYCLE_CAP  = 4000000;
	localparam int HOLD_LEN   = 3000;
	localparam int N_PHASE    = 10;
	localparam int PHASE_ITEMS = 92;

	typedef struct packed {
		logic [COL_W-1:0]  column_out;
		logic [ROW_W-1:0]  draw_start;
		logic [ROW_W-1:0]  draw_end;
		logic [TILE_W-1:0] hit_tile;
		logic              hit_side;
		logic              stripe;
	} slice_t;

	typedef struct {
		logic              command;
		logic [COL_W-1:0]  column;
		logic [TXY_W-1:0]  tile_x;
		logic [TXY_W-1:0]  tile_y;
		logic [TILE_W-1:0] tile_value;
		bit                typed;      // expected slice given in the row
		slice_t            slice;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	dwc_req_if req_ch();
	dwc_res_if res_ch();

	dda_wall_column_raycaster dut (
		.clk(clk), .arst_n(arst_n), .request(req_ch), .result(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the camera and map registers
	logic [15:0]        cam_pos_x, cam_pos_y;
	logic signed [15:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
	logic [5:0]         map_w, map_h;
	logic [TILE_W-1:0]  tile_map [MDIM*MDIM];

	slice_t pending_slices[$];
	int     mismatches = 0;
	int     slices_seen = 0;
	int     casts_sent = 0, writes_sent = 0, reg_writes = 0;
	int     cycle_no = 0;
	int     tx_idle = 0, rx_idle = 0;
	int     hold_asks = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Hang guard
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d slices pending", cycle_no,
				pending_slices.size());
			$display("dda_wall_column_raycaster verification failed");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request
	int hold_left = 0;
	int holds_seen = 0;
	always @(posedge clk) begin
		if (holds_seen != hold_asks) begin
			holds_seen = hold_asks;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Compare each accepted slice with the oldest prediction
	always @(posedge clk) begin
		slice_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{res_ch.column_out, res_ch.draw_start, res_ch.draw_end,
				res_ch.hit_tile, res_ch.hit_side, res_ch.stripe};
			slices_seen++;
			if (pending_slices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected slice col %0d", got.column_out);
			end else begin
				want = pending_slices.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("slice mismatch: want col %0d rows %0d..%0d tile %0d",
							want.column_out, want.draw_start, want.draw_end,
							want.hit_tile);
						$display("  want side %0d stripe %0d", want.hit_side,
							want.stripe);
						$display("  got col %0d rows %0d..%0d tile %0d side %0d stripe %0d",
							got.column_out, got.draw_start, got.draw_end,
							got.hit_tile, got.hit_side, got.stripe);
					end
				end
			end
		end
	end

	function automatic longint floor_q14(longint v);
		if (v >= 0)
			return v / 16384;
		return -((-v + 16383) / 16384);
	endfunction

	function automatic logic [TILE_W-1:0] tile_at(longint x, longint y);
		longint w, h;
		w = (map_w > MDIM) ? MDIM : map_w;
		h = (map_h > MDIM) ? MDIM : map_h;
		if (x < 0 || y < 0 || x >= w || y >= h)
			return 3'd1;
		return tile_map[y * MDIM + x];
	endfunction

	function automatic longint unsigned recip_q16(longint ray);
		longint unsigned mag;
		mag = (ray < 0) ? -ray : ray;
		if (mag == 0)
			return 64'hFFFF_FFFF;
		return (64'd1 << 30) / mag;
	endfunction

	function automatic longint unsigned first_side(longint ray, logic [15:0] pos,
			longint unsigned delta);
		longint unsigned f;
		f = pos[FRAC_W-1:0];
		if (ray >= 0)
			f = 2048 - f;
		return (f * delta) >> 11;
	endfunction

	// Walk the ray for one column and build the slice it should produce
	function automatic slice_t cast_column(logic [COL_W-1:0] col);
		longint cam, rx, ry, mx, my, sx, sy, lh, half, ds, de, wall;
		longint unsigned ddx, ddy, sdx, sdy, perp, q;
		logic [TILE_W-1:0] hit;
		logic side;
		slice_t s;
		hit = 3'd1;
		side = 1'b0;
		cam = ((2 * longint'(col) - SCR_W) * 16384) / SCR_W;
		rx = longint'(cam_dir_x) + floor_q14(longint'(cam_plane_x) * cam);
		ry = longint'(cam_dir_y) + floor_q14(longint'(cam_plane_y) * cam);
		mx = cam_pos_x >> FRAC_W;
		my = cam_pos_y >> FRAC_W;
		ddx = recip_q16(rx);
		ddy = recip_q16(ry);
		sx = (rx < 0) ? -1 : 1;
		sy = (ry < 0) ? -1 : 1;
		sdx = first_side(rx, cam_pos_x, ddx);
		sdy = first_side(ry, cam_pos_y, ddy);
		for (int n = 0; n < 2 * MDIM + 4; n++) begin
			if (sdx < sdy) begin
				sdx += ddx; mx += sx; side = 1'b0;
			end else begin
				sdy += ddy; my += sy; side = 1'b1;
			end
			hit = tile_at(mx, my);
			if (hit != 0)
				break;
		end
		if (hit == 0)
			hit = 3'd1;
		perp = (side == 1'b0) ? sdx - ddx : sdy - ddy;
		if (perp == 0) begin
			lh = 4 * SCR_H;
		end else begin
			q = (longint'(SCR_H) << 16) / perp;
			lh = (q > 4 * SCR_H) ? 4 * SCR_H : longint'(q);
		end
		half = lh / 2;
		ds = SCR_H / 2 - half;
		if (ds < 0)
			ds = 0;
		de = half + SCR_H / 2;
		if (de >= SCR_H)
			de = SCR_H - 1;
		if (side == 1'b0)
			wall = longint'(cam_pos_y) * 524288 + longint'(perp) * ry;
		else
			wall = longint'(cam_pos_x) * 524288 + longint'(perp) * rx;
		s.column_out = col;
		s.draw_start = ds[7:0];
		s.draw_end   = de[7:0];
		s.hit_tile   = hit;
		s.hit_side   = side;
		s.stripe     = wall[27];
		return s;
	endfunction

	// Register write: setup cycle, then access cycle
	task automatic reg_write(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx)); pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_POS_X:   cam_pos_x = val;
			REG_POS_Y:   cam_pos_y = val;
			REG_DIR_X:   cam_dir_x = val;
			REG_DIR_Y:   cam_dir_y = val;
			REG_PLANE_X: cam_plane_x = val;
			REG_PLANE_Y: cam_plane_y = val;
			REG_MAP_W:   map_w = val[5:0];
			REG_MAP_H:   map_h = val[5:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Let the block go idle: all slices in, then time for a trailing write
	task automatic settle();
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic load_camera(logic [15:0] v [8]);
		settle();
		for (int i = 0; i < 8; i++)
			reg_write(reg_idx_t'(i), v[i]);
	endtask

	// Offer one item; valid stays high into the next call unless we idle
	task automatic offer(stim_row_t r);
		if ($urandom_range(99) < tx_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= r.command;
		req_ch.column     <= r.column;
		req_ch.tile_x     <= r.tile_x;
		req_ch.tile_y     <= r.tile_y;
		req_ch.tile_value <= r.tile_value;
		do @(posedge clk); while (!req_ch.ready);
		// accepted at this edge: update the shadow map or predict the slice
		if (r.command == CMD_WRITE) begin
			tile_map[{r.tile_y, r.tile_x}] = r.tile_value;
			writes_sent++;
		end else begin
			pending_slices.push_back(r.typed ? r.slice : cast_column(r.column));
			casts_sent++;
		end
	endtask

	function automatic stim_row_t random_item();
		stim_row_t r;
		r.typed = 1'b0;
		r.slice = '0;
		r.command = ($urandom_range(99) < 15) ? CMD_WRITE : CMD_CAST;
		r.column = ($urandom_range(9) == 0) ? COL_W'($urandom_range(511))
			: COL_W'($urandom_range(SCR_W - 1));
		r.tile_x = TXY_W'($urandom_range(31));
		r.tile_y = TXY_W'($urandom_range(31));
		r.tile_value = ($urandom_range(99) < 65) ? 3'd0 : TILE_W'($urandom_range(7));
		return r;
	endfunction

	stim_row_t directed [] = '{
		// every cell a wall, centred viewer facing +x: half-cell distance fills the column
		'{CMD_CAST, 9'd160, 5'd0, 5'd0, 3'd0, 1'b1, '{9'd160, 8'd0, 8'd239, 3'd1, 1'b0, 1'b0}},
		'{CMD_CAST, 9'd0,   5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd319, 5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd320, 5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd511, 5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd1,   5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_WRITE, 9'd0,   5'd0,  5'd0,  3'd0, 1'b0, '0},
		'{CMD_WRITE, 9'd511, 5'd31, 5'd31, 3'd7, 1'b0, '0},
		'{CMD_WRITE, 9'd0,   5'd31, 5'd0,  3'd5, 1'b0, '0},
		'{CMD_WRITE, 9'd0,   5'd0,  5'd31, 3'd6, 1'b0, '0},
		'{CMD_WRITE, 9'd0,   5'd21, 5'd10, 3'd2, 1'b0, '0},
		'{CMD_WRITE, 9'd0,   5'd10, 5'd21, 3'd1, 1'b0, '0},
		'{CMD_CAST, 9'd256, 5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd255, 5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd80,  5'd0, 5'd0, 3'd0, 1'b0, '0},
		'{CMD_CAST, 9'd240, 5'd0, 5'd0, 3'd0, 1'b0, '0}
	};

	// Camera settings per phase: pos x/y, dir x/y, plane x/y, map width/height
	logic [15:0] fixed_set [6][8] = '{
		'{16'd3072, 16'd3072, 16'd16384, 16'd0, 16'd0, 16'd10813, 16'd10, 16'd10},
		'{16'd0, 16'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'd32, 16'd32},
		'{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd63, 16'd63},
		// facing -x from a cell edge: zero distance and a zero y component
		'{16'd2048, 16'd4096, 16'hC000, 16'd0, 16'd0, 16'd0, 16'd1, 16'd32},
		// null ray: both reciprocals saturate
		'{16'd5000, 16'd7000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd20, 16'd5},
		'{16'd12345, 16'd30000, 16'd0, 16'd16384, 16'hD5C3, 16'd0, 16'd32, 16'd32}
	};

	initial begin
		logic [15:0] cfg [8];
		stim_row_t r;
		arst_n = 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		req_ch.valid <= 1'b0; req_ch.command <= CMD_CAST; req_ch.column <= '0;
		req_ch.tile_x <= '0; req_ch.tile_y <= '0; req_ch.tile_value <= '0;
		cam_pos_x = 16'd3072; cam_pos_y = 16'd3072;
		cam_dir_x = 16'sd16384; cam_dir_y = 16'sd0;
		cam_plane_x = 16'sd0; cam_plane_y = 16'sd10813;
		map_w = 6'd10; map_h = 6'd10;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero map size so nothing unwritten is ever read
		tx_idle = 26; rx_idle = 59;
		reg_write(REG_MAP_W, 16'd0);
		reg_write(REG_MAP_H, 16'd0);
		foreach (directed[i])
			offer(directed[i]);

		// Fill the whole store, mostly empty cells
		for (int c = 0; c < MDIM * MDIM; c++) begin
			r = random_item();
			r.command = CMD_WRITE;
			r.tile_x = TXY_W'(c % MDIM);
			r.tile_y = TXY_W'(c / MDIM);
			offer(r);
		end

		for (int p = 0; p < N_PHASE; p++) begin
			if (p < 4) begin
				tx_idle = 26; rx_idle = 59;
			end else if (p < 7) begin
				tx_idle = 59; rx_idle = 26;
			end else begin
				tx_idle = 0; rx_idle = 0;
			end
			if (p < 6) begin
				cfg = fixed_set[p];
			end else begin
				cfg[0] = 16'($urandom_range(16'hFFFF));
				cfg[1] = 16'($urandom_range(16'hFFFF));
				for (int k = 2; k < 6; k++)
					cfg[k] = 16'($urandom_range(16'hFFFF));
				cfg[6] = 16'($urandom_range(63));
				cfg[7] = 16'($urandom_range(63));
			end
			req_ch.valid <= 1'b0;
			load_camera(cfg);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// stall the output long enough to back up the input
				if (p == 2 && i == 10)
					hold_asks++;
				// hold off the input until every slice is back
				if (p == 5 && i == PHASE_ITEMS / 2) begin
					req_ch.valid <= 1'b0;
					while (pending_slices.size() != 0)
						@(posedge clk);
				end
				offer(random_item());
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d casts, %0d tile writes, %0d register writes over %0d settings",
			casts_sent, writes_sent, reg_writes, N_PHASE + 1);
		$display("%0d slices checked, %0d mismatches", slices_seen, mismatches);
		if (mismatches == 0) begin
			$display("dda_wall_column_raycaster verification clean");
		end else begin
			$display("dda_wall_column_raycaster verification failed");
		end
		$finish;
	end

endmodule
